// ----- hdl/gwm_pkg.sv -----
// Shared constants for the glob wildcard matcher.
package gwm_pkg;

    // Pattern storage: four 64-bit words, eight bytes each.
    localparam int STORED_BYTES = 32;
    localparam int WORD_BYTES   = 8;
    localparam int NUM_WORDS    = STORED_BYTES / WORD_BYTES;
    localparam int WORD_W       = 64;

    // Width of the pattern length register.
    localparam int LEN_W        = 6;

    // Configuration write port.
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD3  = 3'd4;

    // Wildcard bytes.
    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QUERY_BYTE = 8'h3F;

endpackage

// ----- hdl/glob_wildcard_matcher_core.sv -----
// Top level of the glob wildcard matcher.
// Streams file-name bytes against a glob pattern of up to 32 bytes held in
// five write-only registers: pattern_length (index 0) and four 64-bit words of
// pattern bytes (indexes 1..4, byte 0 in the low bits). '*' matches any run of
// bytes, '?' exactly one byte, any other byte (zero included) only itself.
// The block keeps a set of active pattern positions, one bit per position,
// closed over stars. Each name byte moves the set one step; on the byte marked
// last_char one request carries matched (whole name against whole pattern),
// and the set goes back to the start set. A pattern length of zero matches
// every name; lengths beyond MAX_PATTERN or 32 are capped. A write to any of the
// five registers drops a partly streamed name. Rate: one name byte per clock,
// sustained; a request comes from the result register, which takes the flag
// when the last byte leaves the input register. The figure is set by the
// single-pass update of the position set: per-position byte compares followed
// by a log-depth star closure, all combinational. A waiting result only holds
// back a later last byte; other bytes keep flowing.
module glob_wildcard_matcher_core #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          write_en,
    input  logic [gwm_pkg::CFG_IDX_W-1:0] write_index,
    input  logic [gwm_pkg::WORD_W-1:0]    write_data,
    // name bytes in
    input  logic                          name_valid,
    output logic                          name_stall,
    input  logic [7:0]                    name_char,
    input  logic                          last_char,
    // match result out
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          matched
);

    // Positions actually usable: capped by storage.
    localparam int USED    = (MAX_PATTERN < gwm_pkg::STORED_BYTES) ?
                             MAX_PATTERN : gwm_pkg::STORED_BYTES;
    localparam int NUM_POS = USED + 1;

    // ---------------- configuration registers ----------------
    logic [gwm_pkg::LEN_W-1:0]  pat_len_reg;
    logic [gwm_pkg::WORD_W-1:0] pat_word_reg [gwm_pkg::NUM_WORDS];
    logic                       cfg_hit;

    always_comb
    begin
        unique case (write_index)
            gwm_pkg::REG_PATTERN_LENGTH,
            gwm_pkg::REG_PATTERN_WORD0,
            gwm_pkg::REG_PATTERN_WORD1,
            gwm_pkg::REG_PATTERN_WORD2,
            gwm_pkg::REG_PATTERN_WORD3: cfg_hit = write_en;
            default:                    cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg <= '0;
            for (int w = 0; w < gwm_pkg::NUM_WORDS; w++)
            begin
                pat_word_reg[w] <= '0;
            end
        end
        else if (write_en)
        begin
            unique case (write_index)
                gwm_pkg::REG_PATTERN_LENGTH: pat_len_reg     <= write_data[gwm_pkg::LEN_W-1:0];
                gwm_pkg::REG_PATTERN_WORD0:  pat_word_reg[0] <= write_data;
                gwm_pkg::REG_PATTERN_WORD1:  pat_word_reg[1] <= write_data;
                gwm_pkg::REG_PATTERN_WORD2:  pat_word_reg[2] <= write_data;
                gwm_pkg::REG_PATTERN_WORD3:  pat_word_reg[3] <= write_data;
                default:                     ;
            endcase
        end
    end

    // Effective length, capped at the usable positions.
    logic [gwm_pkg::LEN_W-1:0] eff_len;
    assign eff_len = (pat_len_reg > gwm_pkg::LEN_W'(USED)) ? gwm_pkg::LEN_W'(USED) : pat_len_reg;

    // ---------------- input stage ----------------
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic       s1_go;
    logic       s1_fire;
    logic       in_fire;

    logic       result_valid_reg, result_valid_next;
    logic       matched_reg;

    // Non-last bytes never wait; a last byte waits for the result slot.
    assign s1_go      = !s1_last_reg || !result_valid_reg || !result_stall;
    assign s1_fire    = s1_valid_reg && s1_go;
    assign name_stall = s1_valid_reg && !s1_go;
    assign in_fire    = name_valid && !name_stall;

    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_char_reg <= name_char;
            s1_last_reg <= last_char;
        end
    end

    // ---------------- per-position decode ----------------
    logic [USED-1:0]    is_star;
    logic [USED-1:0]    lane_hit;
    logic [NUM_POS-1:0] accept_pos;

    genvar i;
    for (i = 0; i < USED; i++)
    begin : g_lane
        logic [7:0] pbyte;
        logic       lane_on;
        assign pbyte    = pat_word_reg[i / gwm_pkg::WORD_BYTES][(i % gwm_pkg::WORD_BYTES) * 8 +: 8];
        assign lane_on  = gwm_pkg::LEN_W'(i) < eff_len;
        assign is_star[i]  = lane_on && (pbyte == gwm_pkg::STAR_BYTE);
        assign lane_hit[i] = lane_on && (pbyte != gwm_pkg::STAR_BYTE) &&
                             ((pbyte == gwm_pkg::QUERY_BYTE) || (pbyte == s1_char_reg));
    end

    for (i = 0; i < NUM_POS; i++)
    begin : g_acc
        assign accept_pos[i] = (eff_len == gwm_pkg::LEN_W'(i));
    end

    // ---------------- position set ----------------
    logic [NUM_POS-1:0] active_reg;
    logic               restart_reg;
    logic [NUM_POS-1:0] start_set;
    logic [NUM_POS-1:0] cur_set;
    logic [NUM_POS-1:0] step_seed;
    logic [NUM_POS-1:0] next_set;
    logic               matched_next;

    // Start set: position 0 closed over leading stars.
    gwm_star_close #(
        .NUM_POS (NUM_POS)
    ) u_start_close (
        .seed   ({{(NUM_POS-1){1'b0}}, 1'b1}),
        .star   (is_star),
        .closed (start_set)
    );

    // restart_reg stands for "set equals start set of the current pattern",
    // so a config write takes effect without reloading active_reg.
    assign cur_set   = restart_reg ? start_set : active_reg;
    assign step_seed = {1'b0, cur_set[USED-1:0] & is_star} |
                       {cur_set[USED-1:0] & lane_hit, 1'b0};

    gwm_star_close #(
        .NUM_POS (NUM_POS)
    ) u_step_close (
        .seed   (step_seed),
        .star   (is_star),
        .closed (next_set)
    );

    assign matched_next = (eff_len == '0) || (|(next_set & accept_pos));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_reg <= 1'b1;
        end
        else if (cfg_hit)
        begin
            restart_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            restart_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            active_reg <= next_set;
        end
    end

    // ---------------- result register ----------------
    assign result_valid_next = (s1_fire && s1_last_reg) || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            matched_reg <= matched_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign matched      = matched_reg;

`ifndef SYNTHESIS
    // A result appears only right after a last byte leaves the input stage.
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(s1_fire && s1_last_reg))
        else $error("result raised without a last byte");

    // Only a last byte can be held in the input stage.
    a_nonlast_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_last_reg) |-> !name_stall)
        else $error("non-last byte stalled");

    // An empty pattern matches every name.
    a_empty_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg && (eff_len == '0)) |=> matched_reg)
        else $error("empty pattern did not match");

    // The set goes back to the start set after each name.
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> restart_reg)
        else $error("position set not restarted after last byte");
`endif

endmodule

// ----- hdl/gwm_star_close.sv -----
// Star closure of a pattern position set, as a log-depth parallel prefix.
module gwm_star_close #(
    parameter int NUM_POS = 33
) (
    input  logic [NUM_POS-1:0] seed,
    input  logic [NUM_POS-2:0] star,
    output logic [NUM_POS-1:0] closed
);

    localparam int LVL = $clog2(NUM_POS);

    // gen: position reachable within the current window.
    // prop: every star between j-span and j is in the pattern.
    logic [NUM_POS-1:0] gen_lvl  [LVL+1];
    logic [NUM_POS-1:0] prop_lvl [LVL];

    assign gen_lvl[0]  = seed;
    assign prop_lvl[0] = {star, 1'b0};

    genvar l, j;
    for (l = 0; l < LVL; l++)
    begin : g_lvl
        localparam int SPAN = 1 << l;
        for (j = 0; j < NUM_POS; j++)
        begin : g_pos
            if (j >= SPAN)
            begin : g_hi
                assign gen_lvl[l+1][j] = gen_lvl[l][j] | (prop_lvl[l][j] & gen_lvl[l][j-SPAN]);
            end
            else
            begin : g_lo
                assign gen_lvl[l+1][j] = gen_lvl[l][j];
            end
            if (l < LVL - 1)
            begin : g_prop
                if (j >= SPAN)
                begin : g_phi
                    assign prop_lvl[l+1][j] = prop_lvl[l][j] & prop_lvl[l][j-SPAN];
                end
                else
                begin : g_plo
                    assign prop_lvl[l+1][j] = 1'b0;
                end
            end
        end
    end

    assign closed = gen_lvl[LVL];

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for glob_wildcard_matcher_core: directed table, then random patterns.
module testbench;

    localparam int MAX_PAT       = 32;
    localparam int RANDOM_BYTES  = 600;
    // Result register sits behind the input register; leave margin.
    localparam int SETTLE_CYCLES = 6;
    localparam int PLAN_ROWS     = 34;

    // Indexes past the last pattern word: the block must ignore writes to them.
    localparam logic [gwm_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [gwm_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam logic [gwm_pkg::WORD_W-1:0] ALL_STARS =
        {gwm_pkg::WORD_BYTES{gwm_pkg::STAR_BYTE}};
    localparam logic [gwm_pkg::WORD_W-1:0] ALL_ONES  = '1;

    typedef enum logic { ROW_WRITE, ROW_BYTE } row_kind_e;

    // One name byte request, plus an optional typed-in expectation for its result.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       pinned;
        logic       pin_val;
    } name_byte_t;

    typedef struct packed {
        row_kind_e                      kind;
        logic [gwm_pkg::CFG_IDX_W-1:0]  idx;
        logic [gwm_pkg::WORD_W-1:0]     data;
        name_byte_t                     item;
    } plan_row_t;

    // ---------------------------------------------------------------- DUT I/O
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          write_en     = 1'b0;
    logic [gwm_pkg::CFG_IDX_W-1:0] write_index  = '0;
    logic [gwm_pkg::WORD_W-1:0]    write_data   = '0;
    logic                          name_valid   = 1'b0;
    logic                          name_stall;
    logic [7:0]                    name_char    = '0;
    logic                          last_char    = 1'b0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic                          matched;

    glob_wildcard_matcher_core #(.MAX_PATTERN(MAX_PAT)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_en     (write_en),
        .write_index  (write_index),
        .write_data   (write_data),
        .name_valid   (name_valid),
        .name_stall   (name_stall),
        .name_char    (name_char),
        .last_char    (last_char),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .matched      (matched)
    );

    // ------------------------------------------------------ matcher predictor
    // Shadow copy of the pattern registers and of the active position set.
    // Bit i of the set: the first i pattern bytes have matched so far.
    logic [gwm_pkg::LEN_W-1:0]  pat_len = '0;
    logic [gwm_pkg::WORD_W-1:0] pat_words [gwm_pkg::NUM_WORDS] = '{default: '0};
    logic [MAX_PAT:0]           active_set = {{MAX_PAT{1'b0}}, 1'b1};

    logic       matched_q [$];   // expected match flags, oldest first
    name_byte_t send_q [$];      // name bytes waiting to be offered

    bit  calm;                   // phase with no gaps and no stalls
    int  gap_left, stall_left;
    bit  stall_on;
    int  fault_cnt, bytes_taken, results_checked, hits, settings, queued;
    name_byte_t on_wire;

    // Lengths past MAX_PATTERN or the 32 stored bytes are capped.
    function automatic int eff_len();
        int n = int'(pat_len);
        if (n > MAX_PAT) n = MAX_PAT;
        if (n > gwm_pkg::STORED_BYTES) n = gwm_pkg::STORED_BYTES;
        return n;
    endfunction

    function automatic logic [7:0] pat_byte(int i);
        return pat_words[i / gwm_pkg::WORD_BYTES][(i % gwm_pkg::WORD_BYTES) * 8 +: 8];
    endfunction

    // A live star position also makes the position past it live. Walking
    // upward handles runs of stars in one pass.
    function automatic logic [MAX_PAT:0] star_close(logic [MAX_PAT:0] s);
        int n = eff_len();
        for (int i = 0; i < n; i++)
            if (s[i] && pat_byte(i) == gwm_pkg::STAR_BYTE) s[i + 1] = 1'b1;
        return s;
    endfunction

    function automatic logic [MAX_PAT:0] start_set();
        return star_close({{MAX_PAT{1'b0}}, 1'b1});
    endfunction

    // Advance the set by one accepted name byte; the last byte yields a flag.
    task automatic take_name_byte(name_byte_t b);
        logic [MAX_PAT:0] nxt;
        logic [7:0]       p;
        logic             hit;
        int               n;
        nxt = '0;
        n   = eff_len();
        for (int i = 0; i < n; i++) begin
            if (active_set[i]) begin
                p = pat_byte(i);
                if (p == gwm_pkg::STAR_BYTE)
                    nxt[i] = 1'b1;          // star absorbs this byte
                else if (p == gwm_pkg::QUERY_BYTE || p == b.ch)
                    nxt[i + 1] = 1'b1;      // zero bytes compare like any other
            end
        end
        active_set = star_close(nxt);
        if (b.last) begin
            // Empty pattern matches every name; otherwise the end must be live.
            hit = (n == 0) || active_set[n];
            matched_q.push_back(b.pinned ? b.pin_val : hit);
            active_set = start_set();
        end
        bytes_taken++;
    endtask

    // --------------------------------------------------------------- helpers
    function automatic plan_row_t plan_write(logic [gwm_pkg::CFG_IDX_W-1:0] idx,
                                             logic [gwm_pkg::WORD_W-1:0] data);
        return '{kind: ROW_WRITE, idx: idx, data: data, item: '0};
    endfunction

    function automatic plan_row_t plan_byte(logic [7:0] ch, logic last);
        return '{kind: ROW_BYTE, idx: '0, data: '0, item: '{ch, last, 1'b0, 1'b0}};
    endfunction

    // Last byte whose flag is obvious from the pattern.
    function automatic plan_row_t plan_pinned(logic [7:0] ch, logic want);
        return '{kind: ROW_BYTE, idx: '0, data: '0, item: '{ch, 1'b1, 1'b1, want}};
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int burst_len();
        int r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int gap_len();
        return calm ? 0 : burst_len();
    endfunction

    function automatic logic [7:0] name_letter();
        return 8'(8'h61 + $urandom_range(0, 2));
    endfunction

    function automatic logic [7:0] glob_byte();
        int r = $urandom_range(0, 99);
        if (r < 30) return gwm_pkg::STAR_BYTE;
        if (r < 50) return gwm_pkg::QUERY_BYTE;
        if (r < 90) return name_letter();
        return 8'($urandom);
    endfunction

    task automatic note_fault(string what, logic want, logic got);
        fault_cnt++;
        if (fault_cnt <= 10)
            $display("%0t ns: %s: expected matched=%b, got %b", $time, what, want, got);
    endtask

    // Register write; the shadow set restarts just as the block's does.
    task automatic write_reg(logic [gwm_pkg::CFG_IDX_W-1:0] idx,
                             logic [gwm_pkg::WORD_W-1:0] data);
        @(posedge clk);
        write_en    <= 1'b1;
        write_index <= idx;
        write_data  <= data;
        @(posedge clk);
        write_en    <= 1'b0;
        case (idx)
            gwm_pkg::REG_PATTERN_LENGTH: pat_len      = data[gwm_pkg::LEN_W-1:0];
            gwm_pkg::REG_PATTERN_WORD0:  pat_words[0] = data;
            gwm_pkg::REG_PATTERN_WORD1:  pat_words[1] = data;
            gwm_pkg::REG_PATTERN_WORD2:  pat_words[2] = data;
            gwm_pkg::REG_PATTERN_WORD3:  pat_words[3] = data;
            default: ;
        endcase
        if (idx <= gwm_pkg::REG_PATTERN_WORD3) active_set = start_set();
        @(negedge clk);
    endtask

    // Hold until every queued byte is taken and every flag has come back.
    task automatic wait_idle();
        do @(negedge clk);
        while (send_q.size() != 0 || name_valid || matched_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_random_pattern();
        logic [gwm_pkg::WORD_W-1:0] word;
        logic [gwm_pkg::WORD_W-1:0] len_data;
        int                         r;
        bit                         len_first;
        // Upper bits of the length word are junk the block has to drop.
        len_data = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 65)
            len_data[gwm_pkg::LEN_W-1:0] = gwm_pkg::LEN_W'($urandom_range(0, 8));
        else if (r < 90)
            len_data[gwm_pkg::LEN_W-1:0] = gwm_pkg::LEN_W'($urandom_range(9, 32));
        else
            len_data[gwm_pkg::LEN_W-1:0] = gwm_pkg::LEN_W'($urandom_range(33, 63));
        len_first = 1'($urandom_range(0, 1));
        if (len_first) write_reg(gwm_pkg::REG_PATTERN_LENGTH, len_data);
        for (int w = 0; w < gwm_pkg::NUM_WORDS; w++) begin
            if ($urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, 19);
                if (r == 0)      word = '0;
                else if (r == 1) word = '1;
                else
                    for (int b = 0; b < gwm_pkg::WORD_BYTES; b++)
                        word[b * 8 +: 8] = glob_byte();
                write_reg(gwm_pkg::CFG_IDX_W'(int'(gwm_pkg::REG_PATTERN_WORD0) + w), word);
            end
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(gwm_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      {$urandom, $urandom});
        if (!len_first) write_reg(gwm_pkg::REG_PATTERN_LENGTH, len_data);
        settings++;
    endtask

    // Most names are built to fit the current pattern (some then damaged by
    // one byte); the rest are short noise.
    task automatic queue_random_name();
        logic [7:0] bytes [$];
        logic [7:0] p;
        name_byte_t it;
        int         n, r, pos;
        n = eff_len();
        r = $urandom_range(0, 99);
        if (r < 70) begin
            for (int i = 0; i < n; i++) begin
                p = pat_byte(i);
                if (p == gwm_pkg::STAR_BYTE)
                    repeat ($urandom_range(0, 2)) bytes.push_back(name_letter());
                else if (p == gwm_pkg::QUERY_BYTE)
                    bytes.push_back(8'($urandom));
                else
                    bytes.push_back(p);
            end
            if (r >= 50 && bytes.size() > 0) begin
                pos = $urandom_range(0, bytes.size() - 1);
                case ($urandom_range(0, 2))
                    0:       bytes[pos] = name_letter();
                    1:       bytes.delete(pos);
                    default: bytes.insert(pos, 8'($urandom));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 8))
                bytes.push_back(r < 90 ? name_letter() : 8'($urandom));
        end
        if (bytes.size() == 0) bytes.push_back(name_letter());
        foreach (bytes[i]) begin
            it = '{bytes[i], (i == bytes.size() - 1), 1'b0, 1'b0};
            send_q.push_back(it);
        end
        queued += bytes.size();
    endtask

    // ------------------------------------------------------------------ clock
    initial begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------- both sides of the DUT
    // Outputs are sampled at the edge before any NBA lands; inputs change by NBA.
    always @(posedge clk) begin
        logic want;
        if (rst_n) begin
            // Result side: each accepted request is checked against the oldest flag.
            if (result_valid && !result_stall) begin
                if (matched_q.size() == 0) begin
                    note_fault("result with nothing outstanding", 1'bx, matched);
                end else begin
                    want = matched_q.pop_front();
                    if (matched !== want) note_fault("match flag", want, matched);
                    results_checked++;
                    if (want) hits++;
                end
            end

            // Name side: retire the byte on the wire, then offer the next one.
            // A stalled byte stays put; valid never looks at stall to rise.
            if (name_valid && !name_stall) take_name_byte(on_wire);
            if (!name_valid || !name_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    name_valid <= 1'b0;
                end else if (send_q.size() > 0) begin
                    on_wire     = send_q.pop_front();
                    name_valid <= 1'b1;
                    name_char  <= on_wire.ch;
                    last_char  <= on_wire.last;
                    gap_left    = gap_len();
                end else begin
                    name_valid <= 1'b0;
                end
            end
        end

        // Receiver stalls in bursts; calm phases never stall.
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_on   = !calm && ($urandom_range(0, 2) == 0);
            stall_left = stall_on ? burst_len() : $urandom_range(0, 8);
        end
        result_stall <= stall_on;
    end

    // -------------------------------------------------------------- stimulus
    initial begin
        plan_row_t plan [PLAN_ROWS];
        int        phase, names, hold_at;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        plan = '{
            // Out of reset the pattern is empty: every name matches.
            plan_pinned(8'h61, 1'b1),
            plan_byte(8'h00, 1'b0),
            plan_pinned(8'hFF, 1'b1),
            // "a*?" then a zero literal and an 0xFF literal.
            plan_write(gwm_pkg::REG_PATTERN_LENGTH, 64'd5),
            plan_write(gwm_pkg::REG_PATTERN_WORD0, 64'h0000_00FF_003F_2A61),
            plan_byte(8'h61, 1'b0),
            plan_byte(8'h58, 1'b0),
            plan_byte(8'h00, 1'b0),
            plan_byte(8'hFF, 1'b1),
            plan_byte(8'h61, 1'b0),
            plan_byte(8'h00, 1'b0),
            plan_byte(8'hFF, 1'b1),
            plan_pinned(8'h62, 1'b0),
            // Writes past the last word must leave the pattern alone.
            plan_write(REG_SPARE_FIRST, ALL_ONES),
            plan_write(REG_SPARE_LAST, ALL_STARS),
            plan_byte(8'h61, 1'b0),
            plan_byte(gwm_pkg::QUERY_BYTE, 1'b0),
            plan_byte(8'h00, 1'b0),
            plan_byte(8'hFF, 1'b1),
            // All stars, length word all ones: capped to 32, anything matches.
            plan_write(gwm_pkg::REG_PATTERN_WORD0, ALL_STARS),
            plan_write(gwm_pkg::REG_PATTERN_WORD1, ALL_STARS),
            plan_write(gwm_pkg::REG_PATTERN_WORD2, ALL_STARS),
            plan_write(gwm_pkg::REG_PATTERN_WORD3, ALL_STARS),
            plan_write(gwm_pkg::REG_PATTERN_LENGTH, ALL_ONES),
            plan_pinned(8'h71, 1'b1),
            plan_pinned(8'h00, 1'b1),
            // Full 32-byte pattern: 31 stars, then 'Z' in the top byte.
            plan_write(gwm_pkg::REG_PATTERN_WORD3, 64'h5A2A_2A2A_2A2A_2A2A),
            plan_write(gwm_pkg::REG_PATTERN_LENGTH, 64'd32),
            plan_byte(8'h5A, 1'b1),
            plan_byte(8'h59, 1'b1),
            // One zero literal: only a zero name byte fits.
            plan_write(gwm_pkg::REG_PATTERN_WORD0, 64'd0),
            plan_write(gwm_pkg::REG_PATTERN_LENGTH, 64'd1),
            plan_pinned(8'h00, 1'b1),
            plan_pinned(8'h01, 1'b0)
        };

        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(plan[r].idx, plan[r].data);
            end else begin
                send_q.push_back(plan[r].item);
            end
        end
        settings = 6;
        wait_idle();

        // Random phases: new pattern, then a burst of names against it.
        phase = 0;
        while (queued < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 4) == 0);
            load_random_pattern();
            names   = (eff_len() > 16) ? $urandom_range(3, 6) : $urandom_range(4, 20);
            // Sometimes the sender holds off mid-phase until all flags are back.
            hold_at = (phase == 1 || $urandom_range(0, 5) == 0) ? names / 2 : -1;
            for (int k = 0; k < names; k++) begin
                if (k == hold_at) wait_idle();
                queue_random_name();
            end
            wait_idle();
            phase++;
        end

        $display("Covered %0d name bytes, %0d match flags (%0d hits), %0d pattern settings.",
                 bytes_taken, results_checked, hits, settings);
        $display("Patterns ranged from empty to capped 32-byte, with gaps and stalls mixed in.");
        if (fault_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
